>>> sv/fexp_pkg.sv
package fexp_pkg;

  // Single-precision constants, as raw bit patterns
  localparam logic [31:0] F_LOG2E     = 32'h3FB8AA3B;
  localparam logic [31:0] F_LN2_HI    = 32'h3F317218;
  localparam logic [31:0] F_LN2_LO    = 32'h2F51CF7A;
  localparam logic [31:0] F_HALF      = 32'h3F000000;
  localparam logic [31:0] F_NEG_HALF  = 32'hBF000000;
  localparam logic [31:0] F_ONE       = 32'h3F800000;
  localparam logic [31:0] F_C3        = 32'h3E2AAAAB;
  localparam logic [31:0] F_C4        = 32'h3D2AAAAB;
  localparam logic [31:0] F_C5        = 32'h3C088888;
  localparam logic [31:0] F_MAX       = 32'h7F7FFFFF;
  localparam logic [31:0] F_QNAN      = 32'h7FC00000;
  localparam logic [30:0] MAG_INF     = 31'h7F800000;
  localparam logic [30:0] MAG_LO_CLMP = 31'h42AEAC4F;
  localparam logic [30:0] MAG_HI_CLMP = 31'h42B17217;
  localparam int unsigned EXP_SHIFT   = 23;

  // Count leading zeros of a 48-bit word
  function automatic logic [5:0] lzc48(input logic [47:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 48; i++) begin
      if (v[i]) n = 6'(47 - i);
    end
    return n;
  endfunction

  // Count leading zeros of a 51-bit word
  function automatic logic [5:0] lzc51(input logic [50:0] v);
    logic [5:0] n;
    n = '0;
    for (int i = 0; i < 51; i++) begin
      if (v[i]) n = 6'(50 - i);
    end
    return n;
  endfunction

  // Round to nearest even and pack; m has its leading one at bit 47 and
  // e is the biased exponent of that leading one
  function automatic logic [31:0] round_pack(input logic sgn,
                                             input logic signed [11:0] e,
                                             input logic [47:0] m);
    logic [47:0] mm;
    logic        st;
    logic [5:0]  sh;
    logic [7:0]  ef;
    logic        inc;
    logic [30:0] mag;
    mm = m;
    st = 1'b0;
    ef = e[7:0];
    sh = '0;
    if (e <= 12'sd0) begin
      // Denormalise towards the subnormal range
      ef = '0;
      if (e < -12'sd46) begin
        st = |m;
        mm = '0;
      end else begin
        sh = 6'(12'sd1 - e);
        st = |(m << (6'd48 - sh));
        mm = m >> sh;
      end
    end
    inc = mm[23] & (st | (|mm[22:0]) | mm[24]);
    if (e > 12'sd254) return {sgn, MAG_INF};
    mag = {ef, mm[46:24]} + 31'(inc);
    return {sgn, mag};
  endfunction

  // Single-precision multiply, round to nearest even
  function automatic logic [31:0] fmul(input logic [31:0] a, input logic [31:0] b);
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic [7:0]         ea;
    logic [7:0]         eb;
    logic [47:0]        p;
    logic [47:0]        pn;
    logic [5:0]         lz;
    logic signed [11:0] e;
    ma = {|a[30:23], a[22:0]};
    mb = {|b[30:23], b[22:0]};
    ea = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
    eb = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
    p  = ma * mb;
    if (p == 48'd0) return {a[31] ^ b[31], 31'd0};
    lz = lzc48(p);
    pn = p << lz;
    e  = $signed({4'd0, ea}) + $signed({4'd0, eb}) - 12'sd126 - $signed({6'd0, lz});
    return round_pack(a[31] ^ b[31], e, pn);
  endfunction

  // Single-precision add, round to nearest even
  function automatic logic [31:0] fadd(input logic [31:0] a, input logic [31:0] b);
    logic [31:0]        x;
    logic [31:0]        y;
    logic [23:0]        mx;
    logic [23:0]        my;
    logic [7:0]         ex;
    logic [7:0]         ey;
    logic [7:0]         d;
    logic [50:0]        ax;
    logic [50:0]        by;
    logic [50:0]        s;
    logic [50:0]        sn;
    logic               st;
    logic [5:0]         lz;
    logic [47:0]        m;
    logic signed [11:0] e;
    if (a[30:0] >= b[30:0]) begin
      x = a;
      y = b;
    end else begin
      x = b;
      y = a;
    end
    mx = {|x[30:23], x[22:0]};
    my = {|y[30:23], y[22:0]};
    ex = (x[30:23] == 8'd0) ? 8'd1 : x[30:23];
    ey = (y[30:23] == 8'd0) ? 8'd1 : y[30:23];
    d  = ex - ey;
    ax = {1'b0, mx, 26'd0};
    by = {1'b0, my, 26'd0};
    // Align the smaller operand, jamming lost bits into the lsb
    if (d > 8'd50) begin
      by = {50'd0, |my};
    end else begin
      st = |(by & ~({51{1'b1}} << d));
      by = (by >> d) | {50'd0, st};
    end
    s = (x[31] ^ y[31]) ? (ax - by) : (ax + by);
    if (s == 51'd0) return {x[31] & y[31], 31'd0};
    lz = lzc51(s);
    sn = s << lz;
    m  = {sn[50:4], |sn[3:0]};
    e  = $signed({4'd0, ex}) + 12'sd1 - $signed({6'd0, lz});
    return round_pack(x[31], e, m);
  endfunction

endpackage

>>> sv/float_exp_approx.sv
// Single-precision exp approximation, one operand in and one result out.
// Input channel: valid_i, stall_o, x_bits_i (raw float bits). A beat is
// taken when valid_i is high and stall_o is low.
// Output channel: valid_o, stall_i, result_bits_o (raw float bits). A beat
// leaves when valid_o is high and stall_i is low.
// Throughput is one beat per cycle while the receiver does not stall;
// each pipeline stage holds one step of the chain of dependent operations
// (reduction, degree-five Horner polynomial, exponent insert), and that
// chain sets the depth.
// NaN gives the quiet NaN, arguments at or below the lower clamp give +0
// and at or above the upper clamp give the largest finite float.
// Reset clears all valid bits; the pipeline then accepts a beat at once.
// While the receiver stalls a waiting result, the whole pipeline holds and
// stall_o is raised in the same cycle; bubbles are not squeezed out.
module float_exp_approx import fexp_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  output logic        stall_o,
  input  logic [31:0] x_bits_i,
  output logic        valid_o,
  input  logic        stall_i,
  output logic [31:0] result_bits_o
);

  typedef enum logic [1:0] {SPEC_NONE, SPEC_NAN, SPEC_ZERO, SPEC_MAX} spec_e;

  logic        adv;
  logic [15:1] vld_q;
  spec_e       spec_d;
  spec_e       spec_q [1:14];
  logic [31:0] x_q [1:4];
  logic signed [8:0] k_q [3:14];
  logic [31:0] r_q [7:10];
  logic [31:0] r2_q [8:12];
  logic [31:0] q_q [8:13];
  logic [31:0] kr_q;
  logic [31:0] b5_q;
  logic [31:0] res_q;

  logic [31:0] kf1, t2, a4, b4, s5, r6, r2_7, m7, q7, p8, m9, p10, m11, p12, m13, poly14;
  logic [31:0] half_sel;
  logic [7:0]  t_mag;
  logic [7:0]  t_norm;
  logic [2:0]  t_lz;
  logic signed [8:0] k_d;
  logic [31:0] kr_d;
  logic [31:0] res_d;

  // Advance everything unless a finished result is held
  assign adv     = !(vld_q[15] && stall_i);
  assign stall_o = !adv;

  // Classify the operand: NaN, clamped low, clamped high or ordinary
  always_comb begin
    spec_d = SPEC_NONE;
    if (x_bits_i[30:0] > MAG_INF) begin
      spec_d = SPEC_NAN;
    end else if (x_bits_i[31] && x_bits_i[30:0] >= MAG_LO_CLMP) begin
      spec_d = SPEC_ZERO;
    end else if (!x_bits_i[31] && x_bits_i[30:0] >= MAG_HI_CLMP) begin
      spec_d = SPEC_MAX;
    end
  end

  // Stage 1: kf = x * log2(e)
  fexp_fmul u_s1 (.clk_i, .en_i(adv), .a_i(x_bits_i), .b_i(F_LOG2E), .p_o(kf1));

  // Stage 2: add or subtract one half by the sign of kf
  assign half_sel = (!kf1[31] || kf1[30:0] == 31'd0) ? F_HALF : F_NEG_HALF;
  fexp_fadd u_s2 (.clk_i, .en_i(adv), .a_i(kf1), .b_i(half_sel), .s_o(t2));

  // Stage 3: truncate to an integer k and convert back to float
  always_comb begin
    t_mag = '0;
    if (t2[30:23] >= 8'd127) begin
      t_mag = 8'({1'b1, t2[22:0]} >> (8'd150 - t2[30:23]));
    end
    k_d  = t2[31] ? -$signed({1'b0, t_mag}) : $signed({1'b0, t_mag});
    t_lz = '0;
    for (int i = 0; i < 8; i++) begin
      if (t_mag[i]) t_lz = 3'(7 - i);
    end
    t_norm = t_mag << t_lz;
    kr_d   = (t_mag == 8'd0) ? 32'd0
           : {t2[31], 8'd134 - {5'd0, t_lz}, t_norm[6:0], 16'd0};
  end

  // Stage 4: k * ln2 in high and low parts
  fexp_fmul u_s4a (.clk_i, .en_i(adv), .a_i(kr_q), .b_i(F_LN2_HI), .p_o(a4));
  fexp_fmul u_s4b (.clk_i, .en_i(adv), .a_i(kr_q), .b_i(F_LN2_LO), .p_o(b4));

  // Stages 5 and 6: r = (x - k*hi) - k*lo
  fexp_fadd u_s5 (.clk_i, .en_i(adv), .a_i(x_q[4]), .b_i({~a4[31], a4[30:0]}), .s_o(s5));
  fexp_fadd u_s6 (.clk_i, .en_i(adv), .a_i(s5), .b_i({~b5_q[31], b5_q[30:0]}), .s_o(r6));

  // Stage 7: r squared, innermost Horner product, and 1 + r
  fexp_fmul u_s7a (.clk_i, .en_i(adv), .a_i(r6), .b_i(r6), .p_o(r2_7));
  fexp_fmul u_s7b (.clk_i, .en_i(adv), .a_i(r6), .b_i(F_C5), .p_o(m7));
  fexp_fadd u_s7c (.clk_i, .en_i(adv), .a_i(F_ONE), .b_i(r6), .s_o(q7));

  // Stages 8 to 12: Horner steps
  fexp_fadd u_s8  (.clk_i, .en_i(adv), .a_i(F_C4), .b_i(m7), .s_o(p8));
  fexp_fmul u_s9  (.clk_i, .en_i(adv), .a_i(r_q[8]), .b_i(p8), .p_o(m9));
  fexp_fadd u_s10 (.clk_i, .en_i(adv), .a_i(F_C3), .b_i(m9), .s_o(p10));
  fexp_fmul u_s11 (.clk_i, .en_i(adv), .a_i(r_q[10]), .b_i(p10), .p_o(m11));
  fexp_fadd u_s12 (.clk_i, .en_i(adv), .a_i(F_HALF), .b_i(m11), .s_o(p12));

  // Stages 13 and 14: scale by r squared and add 1 + r
  fexp_fmul u_s13 (.clk_i, .en_i(adv), .a_i(r2_q[12]), .b_i(p12), .p_o(m13));
  fexp_fadd u_s14 (.clk_i, .en_i(adv), .a_i(q_q[13]), .b_i(m13), .s_o(poly14));

  // Stage 15: insert k into the exponent, or pick the clamped value
  always_comb begin
    unique case (spec_q[14])
      SPEC_NAN:  res_d = F_QNAN;
      SPEC_ZERO: res_d = 32'd0;
      SPEC_MAX:  res_d = F_MAX;
      default:   res_d = poly14 + {k_q[14], 23'(0)};
    endcase
  end

  // Valid bits travel with the data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[14:1], valid_i};
    end
  end

  // Side band carried alongside the arithmetic stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      spec_q[1] <= spec_d;
      for (int i = 2; i <= 14; i++) spec_q[i] <= spec_q[i-1];
      x_q[1] <= x_bits_i;
      for (int i = 2; i <= 4; i++) x_q[i] <= x_q[i-1];
      k_q[3] <= k_d;
      for (int i = 4; i <= 14; i++) k_q[i] <= k_q[i-1];
      kr_q <= kr_d;
      b5_q <= b4;
      r_q[7] <= r6;
      for (int i = 8; i <= 10; i++) r_q[i] <= r_q[i-1];
      r2_q[8] <= r2_7;
      for (int i = 9; i <= 12; i++) r2_q[i] <= r2_q[i-1];
      q_q[8] <= q7;
      for (int i = 9; i <= 13; i++) q_q[i] <= q_q[i-1];
      res_q <= res_d;
    end
  end

  assign valid_o       = vld_q[15];
  assign result_bits_o = res_q;

  // A held result freezes the valid bit of every stage
  a_stall_freeze: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stall_o |=> $stable(vld_q))
    else $error("pipeline moved while stalled");

  // A NaN operand is tagged in the first stage
  a_nan_tag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (valid_i && !stall_o && x_bits_i[30:0] > MAG_INF) |=> spec_q[1] == SPEC_NAN)
    else $error("NaN operand not tagged");

  // The last stage fills from the one before when the pipe advances
  a_out_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !stall_o |=> vld_q[15] == $past(vld_q[14]))
    else $error("output valid lost or invented");

endmodule

>>> sv/fexp_fmul.sv
module fexp_fmul import fexp_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] p_o
);

  logic [31:0] p_q;

  // Multiply and register the rounded product
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      p_q <= fmul(a_i, b_i);
    end
  end

  assign p_o = p_q;

endmodule

>>> sv/fexp_fadd.sv
module fexp_fadd import fexp_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [31:0] a_i,
  input  logic [31:0] b_i,
  output logic [31:0] s_o
);

  logic [31:0] s_q;

  // Add and register the rounded sum
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s_q <= fadd(a_i, b_i);
    end
  end

  assign s_o = s_q;

endmodule
